[rtl/hex8_heat_element_matrices_assert.svh]
// Assertion macros shared by the element matrix block.
`ifndef HEX8_HEAT_ELEMENT_MATRICES_ASSERT_SVH
`define HEX8_HEAT_ELEMENT_MATRICES_ASSERT_SVH

`define HEM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define HEM_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define HEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/hem_pkg.sv]
// Types and constants shared by the element matrix block.
package hem_pkg;

   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

   localparam logic [1:0] CSR_DIFF_X = 2'd0;
   localparam logic [1:0] CSR_DIFF_Y = 2'd1;
   localparam logic [1:0] CSR_DIFF_Z = 2'd2;
   localparam logic [1:0] CSR_HEAT   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               store_en;
      logic [2:0]         node;
      logic signed [31:0] shape;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] det;
      logic [31:0]        weight;
      logic               run;
      logic               emit;
   } cmd_type;

   typedef struct packed {
      logic [31:0] dfx;
      logic [31:0] dfy;
      logic [31:0] dfz;
      logic [31:0] heat;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic emitting;
   } back_stat_type;

endpackage

[rtl/hem_channels.sv]
// Handshake channel interfaces for node items and matrix entries.
interface hem_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         node_index;
   logic signed [31:0] shape_value;
   logic signed [31:0] deriv_x;
   logic signed [31:0] deriv_y;
   logic signed [31:0] deriv_z;
   logic signed [31:0] jacobian_det;
   logic [31:0]        weight;
   logic               last_node;
   logic               last_point;

   modport source (output valid, node_index, shape_value, deriv_x, deriv_y, deriv_z,
                   jacobian_det, weight, last_node, last_point, input ready);
   modport sink (input valid, node_index, shape_value, deriv_x, deriv_y, deriv_z,
                 jacobian_det, weight, last_node, last_point, output ready);
endinterface

interface hem_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         row;
   logic [2:0]         col;
   logic signed [47:0] conduct_entry;
   logic signed [47:0] capacity_entry;
   logic signed [47:0] heat_entry;
   logic               last;

   modport source (output valid, row, col, conduct_entry, capacity_entry, heat_entry,
                   last, input ready);
   modport sink (input valid, row, col, conduct_entry, capacity_entry, heat_entry,
                 last, output ready);
endinterface

[rtl/hem_front.sv]
// Front end: accepts node items, classifies them and holds one for the queue.
module hem_front import hem_pkg::*; #(
   parameter int NODES = 8
) (
   input  logic    clock,
   input  logic    reset,
   hem_req_if.sink req,
   output logic    push_valid,
   output cmd_type push_cmd,
   input  logic    push_ready
);

   logic    slot_vld_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   assign req.ready  = !slot_vld_ff || push_ready;
   assign push_valid = slot_vld_ff;
   assign push_cmd   = cmd_ff;

   always_comb begin
      cmd_in.store_en = 32'(req.node_index) < NODES;
      cmd_in.node     = req.node_index;
      cmd_in.shape    = req.shape_value;
      cmd_in.dx       = req.deriv_x;
      cmd_in.dy       = req.deriv_y;
      cmd_in.dz       = req.deriv_z;
      cmd_in.det      = req.jacobian_det;
      cmd_in.weight   = req.weight;
      cmd_in.run      = req.last_node;
      cmd_in.emit     = req.last_node && req.last_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= 1'b0;
      end else if (req.ready) begin
         slot_vld_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[rtl/hem_fifo.sv]
// Short command queue between the front end and the compute engine.
module hem_fifo import hem_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  cmd_type                push_cmd,
   output logic                   push_ready,
   output logic                   pop_valid,
   output cmd_type                pop_cmd,
   input  logic                   pop_ready,
   output logic [QUEUE_CNT_W-1:0] count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff;
   logic [PTR_W-1:0]       rd_ff;
   logic [QUEUE_CNT_W-1:0] cnt_ff;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = cnt_ff != FULL;
   assign pop_valid  = cnt_ff != '0;
   assign pop_cmd    = mem_ff[rd_ff];
   assign count      = cnt_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/hem_mulq.sv]
// Iterative Q24 fractional multiplier with truncation toward zero and saturation.
module hem_mulq import hem_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] a,
   input  logic signed [32:0] b,
   output logic               done,
   output logic signed [47:0] result
);

   localparam int CHUNKS = 3;
   localparam logic [1:0] LAST_CHUNK = 2'(CHUNKS - 1);
   localparam logic [55:0] LIM_POS = 56'h7FFF_FFFF_FFFF;
   localparam logic [55:0] LIM_NEG = 56'h8000_0000_0000;

   logic [47:0] ma_ff;
   logic [31:0] mb_ff;
   logic        neg_ff;
   logic [79:0] acc_ff;
   logic [1:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [47:0] pp;
   logic [79:0] shifted;
   logic [55:0] mag;
   logic [32:0] b_mag;

   always_comb begin
      pp      = 48'(ma_ff[{cnt_ff, 4'd0} +: 16]) * 48'(mb_ff);
      shifted = 80'(pp) << {cnt_ff, 4'd0};
      mag     = acc_ff[79:24];
      b_mag   = b[32] ? 33'd0 - b : b;
      if (!neg_ff) begin
         result = (mag > LIM_POS) ? MAX48 : mag[47:0];
      end else begin
         result = (mag > LIM_NEG) ? MIN48 : 48'd0 - mag[47:0];
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == LAST_CHUNK) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         ma_ff  <= a[47] ? 48'd0 - a : a;
         mb_ff  <= b_mag[31:0];
         neg_ff <= a[47] ^ b[32];
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + shifted;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

endmodule

[rtl/hem_back.sv]
// Compute engine: point store, accumulator memories, per-pair sequencer and entry output.
module hem_back import hem_pkg::*; #(
   parameter int NODES = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          pop_valid,
   input  cmd_type       pop_cmd,
   output logic          pop_ready,
   hem_rsp_if.source     rsp,
   output back_stat_type stat
);

   localparam int KW = $clog2(NODES);
   localparam int AW = 2 * KW;
   localparam int ADEPTH = 1 << AW;
   localparam logic [KW-1:0] LAST_IDX = KW'(NODES - 1);
   localparam logic signed [49:0] MAX50 = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] MIN50 = 50'sh3_8000_0000_0000;

   typedef struct packed {
      logic signed [31:0] shape;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
   } node_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_OP, S_WAIT, S_WB, S_EMIT_RD, S_EMIT_LD
   } state_type;

   typedef enum logic [3:0] {
      OP_H1, OP_H2, OP_H3, OP_X1, OP_X2, OP_Y1, OP_Y2, OP_Z1, OP_Z2,
      OP_SUM, OP_C1, OP_C2, OP_P1, OP_P2, OP_P3
   } op_type;

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] x,
                                                 input logic signed [47:0] y);
      logic signed [48:0] s;
      s = {x[47], x} + {y[47], y};
      if (s[48] != s[47]) begin
         return s[48] ? MIN48 : MAX48;
      end
      return s[47:0];
   endfunction

   function automatic logic signed [47:0] sat_sum3(input logic signed [47:0] x,
                                                  input logic signed [47:0] y,
                                                  input logic signed [47:0] z);
      logic signed [49:0] s;
      s = 50'(x) + 50'(y) + 50'(z);
      if (s > MAX50) begin
         return MAX48;
      end
      if (s < MIN50) begin
         return MIN48;
      end
      return s[47:0];
   endfunction

   state_type          state_ff;
   op_type             op_ff;
   logic [KW-1:0]      k_ff;
   logic [KW-1:0]      l_ff;
   logic signed [31:0] det_ff;
   logic [31:0]        w_ff;
   logic               emit_ff;
   logic signed [47:0] t_ff;
   logic signed [47:0] tx_ff;
   logic signed [47:0] ty_ff;
   logic signed [47:0] tz_ff;
   logic signed [47:0] c_ff;
   logic signed [47:0] p_ff;
   logic signed [47:0] heat_ff [NODES];

   node_type           store_mem [NODES];
   node_type           sk_ff;
   node_type           sl_ff;
   logic signed [47:0] cond_mem [ADEPTH];
   logic signed [47:0] cap_mem [ADEPTH];
   logic [ADEPTH-1:0]  vld_ff;
   logic signed [47:0] cond_rd_ff;
   logic signed [47:0] cap_rd_ff;

   logic               rsp_vld_ff;
   logic [2:0]         row_ff;
   logic [2:0]         col_ff;
   logic signed [47:0] cond_out_ff;
   logic signed [47:0] cap_out_ff;
   logic signed [47:0] heat_out_ff;
   logic               last_out_ff;

   logic [AW-1:0]      addr;
   logic               store_we;
   logic               rd_en;
   logic               wb_en;
   logic               load_out;
   logic               final_entry;
   logic               mul_start;
   logic signed [47:0] mul_a;
   logic signed [32:0] mul_b;
   logic               mul_done;
   logic signed [47:0] mul_res;

   assign addr        = {k_ff, l_ff};
   assign pop_ready   = state_ff == S_IDLE;
   assign store_we    = pop_valid && pop_ready && pop_cmd.store_en;
   assign rd_en       = (state_ff == S_READ) || (state_ff == S_EMIT_RD);
   assign wb_en       = state_ff == S_WB;
   assign load_out    = (state_ff == S_EMIT_LD) && (!rsp_vld_ff || rsp.ready);
   assign final_entry = (k_ff == LAST_IDX) && (l_ff == LAST_IDX);
   assign mul_start   = (state_ff == S_OP) && (op_ff != OP_SUM);

   assign stat.busy     = state_ff != S_IDLE;
   assign stat.emitting = (state_ff == S_EMIT_RD) || (state_ff == S_EMIT_LD);

   assign rsp.valid          = rsp_vld_ff;
   assign rsp.row            = row_ff;
   assign rsp.col            = col_ff;
   assign rsp.conduct_entry  = cond_out_ff;
   assign rsp.capacity_entry = cap_out_ff;
   assign rsp.heat_entry     = heat_out_ff;
   assign rsp.last           = last_out_ff;

   always_comb begin
      mul_a = t_ff;
      mul_b = {det_ff[31], det_ff};
      case (op_ff)
         OP_H1: begin
            mul_a = 48'(cfg.heat);
            mul_b = {sk_ff.shape[31], sk_ff.shape};
         end
         OP_H3, OP_C2, OP_P3: mul_b = {1'b0, w_ff};
         OP_X1: begin
            mul_a = 48'(sk_ff.dx);
            mul_b = {sl_ff.dx[31], sl_ff.dx};
         end
         OP_X2: mul_b = {1'b0, cfg.dfx};
         OP_Y1: begin
            mul_a = 48'(sk_ff.dy);
            mul_b = {sl_ff.dy[31], sl_ff.dy};
         end
         OP_Y2: mul_b = {1'b0, cfg.dfy};
         OP_Z1: begin
            mul_a = 48'(sk_ff.dz);
            mul_b = {sl_ff.dz[31], sl_ff.dz};
         end
         OP_Z2: mul_b = {1'b0, cfg.dfz};
         OP_P1: begin
            mul_a = 48'(sk_ff.shape);
            mul_b = {sl_ff.shape[31], sl_ff.shape};
         end
         default: ;
      endcase
   end

   hem_mulq u_mulq (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[pop_cmd.node[KW-1:0]] <= {pop_cmd.shape, pop_cmd.dx, pop_cmd.dy, pop_cmd.dz};
      end
      if (state_ff == S_READ) begin
         sk_ff <= store_mem[k_ff];
         sl_ff <= store_mem[l_ff];
      end
      if (rd_en) begin
         cond_rd_ff <= vld_ff[addr] ? cond_mem[addr] : '0;
         cap_rd_ff  <= vld_ff[addr] ? cap_mem[addr] : '0;
      end
      if (wb_en) begin
         cond_mem[addr] <= sat_add(cond_rd_ff, c_ff);
         cap_mem[addr]  <= sat_add(cap_rd_ff, p_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (load_out && final_entry) begin
         vld_ff <= '0;
      end else if (wb_en) begin
         vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         op_ff      <= OP_H1;
         k_ff       <= '0;
         l_ff       <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            heat_ff[i] <= '0;
         end
      end else begin
         if (rsp.ready && !load_out) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid && pop_cmd.run) begin
                  det_ff   <= pop_cmd.det;
                  w_ff     <= pop_cmd.weight;
                  emit_ff  <= pop_cmd.emit;
                  k_ff     <= '0;
                  l_ff     <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               op_ff    <= (l_ff == '0) ? OP_H1 : OP_X1;
               state_ff <= S_OP;
            end
            S_OP: begin
               if (op_ff == OP_SUM) begin
                  t_ff  <= sat_sum3(tx_ff, ty_ff, tz_ff);
                  op_ff <= OP_C1;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (mul_done) begin
                  state_ff <= S_OP;
                  case (op_ff)
                     OP_H1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_H2;
                     end
                     OP_H2: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_H3;
                     end
                     OP_H3: begin
                        heat_ff[k_ff] <= sat_add(heat_ff[k_ff], mul_res);
                        op_ff         <= OP_X1;
                     end
                     OP_X1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_X2;
                     end
                     OP_X2: begin
                        tx_ff <= mul_res;
                        op_ff <= OP_Y1;
                     end
                     OP_Y1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_Y2;
                     end
                     OP_Y2: begin
                        ty_ff <= mul_res;
                        op_ff <= OP_Z1;
                     end
                     OP_Z1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_Z2;
                     end
                     OP_Z2: begin
                        tz_ff <= mul_res;
                        op_ff <= OP_SUM;
                     end
                     OP_C1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_C2;
                     end
                     OP_C2: begin
                        c_ff  <= mul_res;
                        op_ff <= OP_P1;
                     end
                     OP_P1: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_P2;
                     end
                     OP_P2: begin
                        t_ff  <= mul_res;
                        op_ff <= OP_P3;
                     end
                     OP_P3: begin
                        p_ff     <= mul_res;
                        state_ff <= S_WB;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_WB: begin
               if (l_ff == LAST_IDX) begin
                  l_ff <= '0;
                  if (k_ff == LAST_IDX) begin
                     k_ff     <= '0;
                     state_ff <= emit_ff ? S_EMIT_RD : S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= S_READ;
                  end
               end else begin
                  l_ff     <= l_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT_LD;
            end
            S_EMIT_LD: begin
               if (load_out) begin
                  rsp_vld_ff  <= 1'b1;
                  row_ff      <= 3'(k_ff);
                  col_ff      <= 3'(l_ff);
                  cond_out_ff <= cond_rd_ff;
                  cap_out_ff  <= cap_rd_ff;
                  heat_out_ff <= heat_ff[k_ff];
                  last_out_ff <= final_entry;
                  if (final_entry) begin
                     k_ff     <= '0;
                     l_ff     <= '0;
                     state_ff <= S_IDLE;
                     for (int i = 0; i < NODES; i++) begin
                        heat_ff[i] <= '0;
                     end
                  end else begin
                     if (l_ff == LAST_IDX) begin
                        l_ff <= '0;
                        k_ff <= k_ff + 1'b1;
                     end else begin
                        l_ff <= l_ff + 1'b1;
                     end
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/hex8_heat_element_matrices.sv]
// Top level of the 8-node brick heat conduction element matrix block.
// Node items enter on req_port, one per node and Gauss point; matrix entries leave on
// rsp_port, row by row, NODES*NODES of them per element, the last one flagged.
// The csr_ APB port holds the three diffusivities and the heat coefficient; the user is to
// write it while the block is idle, which the block does not enforce. pready is always high.
// An item passes a one-item front register and a two-item queue, so the front keeps
// taking items while the compute engine is busy with an earlier point.
// An item that only stores node data passes the front register and the queue before
// it reaches the engine, and such items pass at one per cycle while the engine is idle.
// The item that closes a point starts the pair sequencer, which runs every product
// through one iterative 16 by 32 bit multiplier, one product at a time, and forms the
// heat vector term once per row.
// The item that closes the last point then makes the engine emit the entries, each read
// and then loaded into the output register when the receiver is ready; a stalled receiver
// holds the current entry and the engine waits, while the queue still fills.
// Synchronous reset clears the valid flags, the configuration, the control state and the
// accumulators; data registers are not reset. The accumulators clear again after the last entry of an element leaves.
module hex8_heat_element_matrices import hem_pkg::*; #(
   parameter int NODES = 8
) (
   input  logic        clock,
   input  logic        reset,
   hem_req_if.sink     req_port,
   hem_rsp_if.source   rsp_port,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "hex8_heat_element_matrices_assert.svh"

   cfg_type                cfg_ff;
   logic                   csr_write;
   logic                   push_valid;
   cmd_type                push_cmd;
   logic                   push_ready;
   logic                   pop_valid;
   cmd_type                pop_cmd;
   logic                   pop_ready;
   logic [QUEUE_CNT_W-1:0] queue_count;
   back_stat_type          back_stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_DIFF_X: cfg_ff.dfx  <= csr_pwdata;
            CSR_DIFF_Y: cfg_ff.dfy  <= csr_pwdata;
            CSR_DIFF_Z: cfg_ff.dfz  <= csr_pwdata;
            CSR_HEAT:   cfg_ff.heat <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_DIFF_X: csr_prdata = cfg_ff.dfx;
         CSR_DIFF_Y: csr_prdata = cfg_ff.dfy;
         CSR_DIFF_Z: csr_prdata = cfg_ff.dfz;
         CSR_HEAT:   csr_prdata = cfg_ff.heat;
         default:    csr_prdata = '0;
      endcase
   end

   hem_front #(.NODES(NODES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   hem_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready),
      .count      (queue_count)
   );

   hem_back #(.NODES(NODES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp       (rsp_port),
      .stat      (back_stat)
   );

   `HEM_ASSERT_ALWAYS(a_queue_bound, queue_count <= QUEUE_CNT_W'(QUEUE_DEPTH),
      "command queue holds more items than its depth")
   `HEM_ASSERT_IMPLY(a_no_pop_emit, back_stat.emitting, !(pop_valid && pop_ready),
      "engine took a command while emitting entries")
   `HEM_ASSERT_NEXT(a_last_ends_emit, rsp_port.valid && rsp_port.ready && rsp_port.last,
      !back_stat.emitting, "engine still emitting after the final entry left")

endmodule
